[rtl/cimr_pkg.sv]
`default_nettype none

package cimr_pkg;

  localparam int IMAGE_BYTES = 16384;
  localparam int PAYLOAD_MAX = 241;

  localparam int AddrW = $clog2(IMAGE_BYTES);
  localparam int LenW = AddrW + 1;
  localparam int OutqDepth = 3;
  localparam int OutqPtrW = $clog2(OutqDepth);
  localparam int OutqCntW = $clog2(OutqDepth + 1);

  localparam logic [7:0] MsgWake = 8'h01;
  localparam logic [7:0] MsgSleep = 8'h02;
  localparam logic [7:0] MsgChunk = 8'h03;
  localparam logic [7:0] MsgSensor = 8'h04;
  localparam logic [15:0] NoImageId = 16'hFFFF;

  typedef enum logic [2:0] {
    StIgnored = 3'd0,
    StSensor  = 3'd1,
    StStored  = 3'd2,
    StDropped = 3'd3,
    StDone    = 3'd4,
    StWake    = 3'd5,
    StSleep   = 3'd6,
    StRead    = 3'd7
  } status_e;

  typedef struct packed {
    logic             cmd;
    logic [7:0]       data_byte;
    logic             last_byte;
    logic [AddrW-1:0] read_address;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic            image_ready;
    logic [LenW-1:0] image_length;
    logic            awake_flag;
    logic            send_setpoint;
    logic [7:0]      temperature;
    logic [7:0]      air_humidity;
    logic [7:0]      battery_one;
    logic [7:0]      battery_two;
    logic [7:0]      soil_one;
    logic [7:0]      soil_two;
    logic [7:0]      read_data;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } ram_wr_t;

endpackage

`default_nettype wire

[rtl/chunked_image_message_receiver.sv]
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_item_i  (cimr_pkg::in_item_t)
// out      output     out_valid_o / out_stall_i out_item_o (cimr_pkg::out_item_t)
//
// One item is taken every cycle while in_stall_o is low; each item is parsed combinationally.
// A result is offered after its item has passed the parser register, which the image store's
// registered read port lines up with, and then a 3-entry queue.
// Input stalls only when that queue could not absorb every result in flight.
// Reset clears all parsing state and the queue; the image store is not cleared.

`default_nettype none

module chunked_image_message_receiver (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cimr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cimr_pkg::out_item_t out_item_o
);

  logic                          in_accept;
  logic                          res_valid;
  logic                          res_read;
  cimr_pkg::out_item_t           res;
  cimr_pkg::out_item_t           push_item;
  cimr_pkg::ram_wr_t             wr;
  logic [7:0]                    ram_rdata;
  logic [cimr_pkg::OutqCntW-1:0] q_cnt;

  assign in_stall_o = (q_cnt == cimr_pkg::OutqCntW'(cimr_pkg::OutqDepth)) ||
                      (res_valid && q_cnt == cimr_pkg::OutqCntW'(cimr_pkg::OutqDepth - 1));
  assign in_accept = in_valid_i && !in_stall_o;

  cimr_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .item_i      (in_item_i),
    .res_valid_o (res_valid),
    .res_read_o  (res_read),
    .res_o       (res),
    .wr_o        (wr)
  );

  cimr_ram #(
    .Width (8),
    .Depth (cimr_pkg::IMAGE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (in_accept && in_item_i.cmd),
    .raddr_i (in_item_i.read_address),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    push_item = res;
    push_item.read_data = res_read ? ram_rdata : 8'h00;
  end

  cimr_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_item_i (push_item),
    .cnt_o       (q_cnt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && q_cnt == cimr_pkg::OutqCntW'(cimr_pkg::OutqDepth)) |-> !out_stall_i)
    else $error("Result queue overflow.");

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_item_i.cmd) |=> (res_valid && res_read))
    else $error("Read item did not produce a result.");

  a_mid_byte_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !in_item_i.cmd && !in_item_i.last_byte) |=> !res_valid)
    else $error("Non-final message byte produced a result.");

  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.image_length <= cimr_pkg::LenW'(cimr_pkg::IMAGE_BYTES)))
    else $error("Assembled length exceeds the image store.");

endmodule

`default_nettype wire

[rtl/cimr_ram.sv]
`default_nettype none

module cimr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/cimr_parse.sv]
`default_nettype none

module cimr_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  cimr_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output logic                res_read_o,
  output cimr_pkg::out_item_t res_o,
  output cimr_pkg::ram_wr_t   wr_o
);

  logic [7:0]                byte_index_q, byte_index_d;
  logic [7:0]                msg_type_q, msg_type_d;
  logic [15:0]               hdr_q [4];
  logic [15:0]               hdr_d [4];
  logic                      accepted_q, accepted_d;
  logic [15:0]               cur_id_q, cur_id_d;
  logic [cimr_pkg::LenW-1:0] asm_len_q, asm_len_d;
  logic                      ready_q, ready_d;
  logic                      awake_q, awake_d;
  logic [7:0]                shadow_q [6];
  logic [7:0]                shadow_d [6];
  logic [7:0]                values_q [6];
  logic [7:0]                values_d [6];
  logic                      res_valid_q, res_valid_d;
  logic                      res_read_q, res_read_d;
  cimr_pkg::out_item_t       res_q, res_d;

  always_comb begin
    logic [7:0]                idx;
    logic [7:0]                b;
    logic [7:0]                typ;
    logic                      restart;
    logic [7:0]                clamp;
    logic [cimr_pkg::LenW-1:0] base;
    logic [cimr_pkg::LenW:0]   need;
    logic [7:0]                off;
    logic [cimr_pkg::LenW-1:0] waddr;
    logic                      setp;
    cimr_pkg::status_e         st;

    idx = byte_index_q;
    b = item_i.data_byte;
    typ = (idx == 8'd0) ? b : msg_type_q;
    setp = 1'b0;
    st = cimr_pkg::StIgnored;

    byte_index_d = byte_index_q;
    msg_type_d = msg_type_q;
    hdr_d = hdr_q;
    accepted_d = accepted_q;
    cur_id_d = cur_id_q;
    asm_len_d = asm_len_q;
    ready_d = ready_q;
    awake_d = awake_q;
    shadow_d = shadow_q;
    values_d = values_q;
    wr_o = '0;

    if (typ == cimr_pkg::MsgChunk) begin
      for (int i = 0; i < 4; i++) begin
        if (idx == 8'(2 * i + 1)) begin
          hdr_d[i] = {8'h00, b};
        end
        if (idx == 8'(2 * i + 2)) begin
          hdr_d[i][15:8] = b;
        end
      end
    end
    if (typ == cimr_pkg::MsgSensor) begin
      for (int i = 0; i < 6; i++) begin
        if (idx == 8'(i + 1)) begin
          shadow_d[i] = b;
        end
      end
    end

    restart = (hdr_d[0] != cur_id_q) || (hdr_d[1] == 16'h0000);
    clamp = (hdr_d[3] > 16'(cimr_pkg::PAYLOAD_MAX)) ? 8'(cimr_pkg::PAYLOAD_MAX) :
            hdr_d[3][7:0];
    base = restart ? '0 : asm_len_q;
    need = {1'b0, base} + (cimr_pkg::LenW + 1)'(clamp);

    if (typ == cimr_pkg::MsgChunk && idx == 8'd8) begin
      if (restart) begin
        cur_id_d = hdr_d[0];
      end
      asm_len_d = base;
      hdr_d[3] = {8'h00, clamp};
      accepted_d = (need <= (cimr_pkg::LenW + 1)'(cimr_pkg::IMAGE_BYTES));
    end

    off = idx - 8'd9;
    waddr = asm_len_d + cimr_pkg::LenW'(off);
    if (typ == cimr_pkg::MsgChunk && idx >= 8'd9 && accepted_d &&
        {8'h00, off} < hdr_d[3] &&
        waddr < cimr_pkg::LenW'(cimr_pkg::IMAGE_BYTES)) begin
      wr_o.en = accept_i && !item_i.cmd;
      wr_o.addr = waddr[cimr_pkg::AddrW-1:0];
      wr_o.data = b;
    end

    if (item_i.last_byte) begin
      byte_index_d = 8'd0;
      case (typ)
        cimr_pkg::MsgSensor: begin
          if (idx == 8'd6) begin
            values_d = shadow_d;
            st = cimr_pkg::StSensor;
          end
        end
        cimr_pkg::MsgChunk: begin
          if (idx >= 8'd8) begin
            ready_d = 1'b0;
            if (accepted_d) begin
              asm_len_d = asm_len_d + cimr_pkg::LenW'(hdr_d[3][7:0]);
              st = cimr_pkg::StStored;
            end else begin
              st = cimr_pkg::StDropped;
            end
            if (hdr_d[1] == hdr_d[2] - 16'd1) begin
              ready_d = 1'b1;
              st = cimr_pkg::StDone;
            end
          end
        end
        cimr_pkg::MsgWake: begin
          awake_d = 1'b1;
          setp = 1'b1;
          st = cimr_pkg::StWake;
        end
        cimr_pkg::MsgSleep: begin
          awake_d = 1'b0;
          st = cimr_pkg::StSleep;
        end
        default: begin
          st = cimr_pkg::StIgnored;
        end
      endcase
    end else begin
      byte_index_d = (idx == 8'hFF) ? idx : idx + 8'd1;
    end
    msg_type_d = typ;

    // A read item or an idle cycle leaves the parsing state untouched.
    if (!accept_i || item_i.cmd) begin
      byte_index_d = byte_index_q;
      msg_type_d = msg_type_q;
      hdr_d = hdr_q;
      accepted_d = accepted_q;
      cur_id_d = cur_id_q;
      asm_len_d = asm_len_q;
      ready_d = ready_q;
      awake_d = awake_q;
      shadow_d = shadow_q;
      values_d = values_q;
      setp = 1'b0;
      st = cimr_pkg::StRead;
    end

    res_valid_d = accept_i && (item_i.cmd || item_i.last_byte);
    res_read_d = accept_i && item_i.cmd;

    res_d.status = st;
    res_d.image_ready = ready_d;
    res_d.image_length = asm_len_d;
    res_d.awake_flag = awake_d;
    res_d.send_setpoint = setp;
    res_d.temperature = values_d[0];
    res_d.air_humidity = values_d[1];
    res_d.battery_one = values_d[2];
    res_d.battery_two = values_d[3];
    res_d.soil_one = values_d[4];
    res_d.soil_two = values_d[5];
    res_d.read_data = 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= 8'd0;
      msg_type_q <= 8'd0;
      for (int i = 0; i < 4; i++) begin
        hdr_q[i] <= 16'h0000;
      end
      accepted_q <= 1'b0;
      cur_id_q <= cimr_pkg::NoImageId;
      asm_len_q <= '0;
      ready_q <= 1'b0;
      awake_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        shadow_q[i] <= 8'h00;
        values_q[i] <= 8'h00;
      end
      res_valid_q <= 1'b0;
      res_read_q <= 1'b0;
    end else begin
      byte_index_q <= byte_index_d;
      msg_type_q <= msg_type_d;
      hdr_q <= hdr_d;
      accepted_q <= accepted_d;
      cur_id_q <= cur_id_d;
      asm_len_q <= asm_len_d;
      ready_q <= ready_d;
      awake_q <= awake_d;
      shadow_q <= shadow_d;
      values_q <= values_d;
      res_valid_q <= res_valid_d;
      res_read_q <= res_read_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_d) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_read_o = res_read_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

[rtl/cimr_outq.sv]
`default_nettype none

module cimr_outq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  cimr_pkg::out_item_t             push_item_i,
  output logic [cimr_pkg::OutqCntW-1:0]   cnt_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cimr_pkg::out_item_t             out_item_o
);

  cimr_pkg::out_item_t                 fifo_q [cimr_pkg::OutqDepth];
  logic [cimr_pkg::OutqPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [cimr_pkg::OutqPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [cimr_pkg::OutqCntW-1:0]       cnt_q, cnt_d;
  logic                                pop;

  localparam logic [cimr_pkg::OutqPtrW-1:0] LastPtr =
    cimr_pkg::OutqPtrW'(cimr_pkg::OutqDepth - 1);

  assign pop = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign cnt_o = cnt_q;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import cimr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomItems = 1350;

  class image_rx_scoreboard;
    logic [7:0]  byte_idx;
    logic [7:0]  msg_type;
    logic [15:0] hdr[4];
    logic        accepted;
    logic [15:0] cur_id;
    int unsigned asm_len;
    logic        ready;
    logic        awake;
    logic [7:0]  shadow[6];
    logic [7:0]  sensors[6];
    logic [7:0]  store[IMAGE_BYTES];
    bit          written[IMAGE_BYTES];
    int          written_list[$];
    int          last_written;
    out_item_t   expected[$];
    int          items_in;
    int          reads_in;
    int          checked;
    int          errors;
    int          seen[8];

    function new();
      byte_idx = '0;
      msg_type = '0;
      foreach (hdr[i]) hdr[i] = '0;
      accepted = 1'b0;
      cur_id = NoImageId;
      asm_len = 0;
      ready = 1'b0;
      awake = 1'b0;
      foreach (shadow[i]) shadow[i] = '0;
      foreach (sensors[i]) sensors[i] = '0;
      last_written = 0;
    endfunction

    function void queue_expected(status_e st, logic setp, logic [7:0] rd);
      out_item_t e;
      e.status = st;
      e.image_ready = ready;
      e.image_length = LenW'(asm_len);
      e.awake_flag = awake;
      e.send_setpoint = setp;
      e.temperature = sensors[0];
      e.air_humidity = sensors[1];
      e.battery_one = sensors[2];
      e.battery_two = sensors[3];
      e.soil_one = sensors[4];
      e.soil_two = sensors[5];
      e.read_data = rd;
      expected.push_back(e);
    endfunction

    function void note_item(in_item_t it);
      logic [7:0]  idx;
      logic [7:0]  b;
      logic [15:0] prev_total;
      status_e     st;
      logic        setp;
      int          k;
      int          off;
      int          a;
      items_in++;
      if (it.cmd) begin
        reads_in++;
        queue_expected(StRead, 1'b0, store[it.read_address]);
        return;
      end
      b = it.data_byte;
      idx = byte_idx;
      if (idx == 8'd0) msg_type = b;
      if (msg_type == MsgChunk) begin
        if (idx >= 8'd1 && idx <= 8'd8) begin
          k = (idx - 1) >> 1;
          if (idx[0]) hdr[k] = {8'h00, b};
          else hdr[k] = {b, hdr[k][7:0]};
          if (idx == 8'd8) begin
            if (hdr[0] != cur_id || hdr[1] == 16'd0) begin
              cur_id = hdr[0];
              asm_len = 0;
            end
            if (hdr[3] > PAYLOAD_MAX) hdr[3] = 16'(PAYLOAD_MAX);
            accepted = (asm_len + hdr[3] <= IMAGE_BYTES);
          end
        end else if (idx >= 8'd9) begin
          off = idx - 9;
          a = asm_len + off;
          if (accepted && off < hdr[3] && a < IMAGE_BYTES) begin
            store[a] = b;
            last_written = a;
            if (!written[a]) begin
              written[a] = 1'b1;
              written_list.push_back(a);
            end
          end
        end
      end else if (msg_type == MsgSensor && idx >= 8'd1 && idx <= 8'd6) begin
        shadow[idx - 1] = b;
      end

      if (!it.last_byte) begin
        if (idx != 8'd255) byte_idx = idx + 8'd1;
        return;
      end
      byte_idx = '0;
      st = StIgnored;
      setp = 1'b0;
      case (msg_type)
        MsgSensor: begin
          if (idx == 8'd6) begin
            sensors = shadow;
            st = StSensor;
          end
        end
        MsgChunk: begin
          if (idx >= 8'd8) begin
            ready = 1'b0;
            if (accepted) begin
              asm_len += hdr[3];
              st = StStored;
            end else begin
              st = StDropped;
            end
            prev_total = hdr[2] - 16'd1;
            if (hdr[1] == prev_total) begin
              ready = 1'b1;
              st = StDone;
            end
          end
        end
        MsgWake: begin
          awake = 1'b1;
          setp = 1'b1;
          st = StWake;
        end
        MsgSleep: begin
          awake = 1'b0;
          st = StSleep;
        end
        default: ;
      endcase
      queue_expected(st, setp, 8'h00);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= 40)
        $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                 checked, what, got, want);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected.size() == 0) begin
        report("unexpected result, status", got.status, 0);
        return;
      end
      want = expected.pop_front();
      checked++;
      seen[want.status]++;
      if (got.status != want.status) report("status", got.status, want.status);
      if (got.image_ready != want.image_ready)
        report("image_ready", got.image_ready, want.image_ready);
      if (got.image_length != want.image_length)
        report("image_length", got.image_length, want.image_length);
      if (got.awake_flag != want.awake_flag)
        report("awake_flag", got.awake_flag, want.awake_flag);
      if (got.send_setpoint != want.send_setpoint)
        report("send_setpoint", got.send_setpoint, want.send_setpoint);
      if (got.temperature != want.temperature)
        report("temperature", got.temperature, want.temperature);
      if (got.air_humidity != want.air_humidity)
        report("air_humidity", got.air_humidity, want.air_humidity);
      if (got.battery_one != want.battery_one)
        report("battery_one", got.battery_one, want.battery_one);
      if (got.battery_two != want.battery_two)
        report("battery_two", got.battery_two, want.battery_two);
      if (got.soil_one != want.soil_one) report("soil_one", got.soil_one, want.soil_one);
      if (got.soil_two != want.soil_two) report("soil_two", got.soil_two, want.soil_two);
      if (got.read_data != want.read_data)
        report("read_data", got.read_data, want.read_data);
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  image_rx_scoreboard sb;
  int burst_left = 0;
  int stall_left = 0;
  int stall_pct = 0;
  int read_pct = 0;
  int cycles = 0;

  chunked_image_message_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver switches between free running, light and heavy stalling.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_pct = $urandom_range(0, 2) * 40;
      stall_left = $urandom_range(10, 150);
    end
    stall_left--;
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        in_item_i <= in_item_t'($urandom);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    burst_left--;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic send_read();
    in_item_t it;
    int n;
    n = sb.written_list.size();
    if (n == 0) return;
    it.cmd = 1'b1;
    it.data_byte = 8'($urandom);
    it.last_byte = 1'($urandom);
    if ($urandom_range(0, 1)) it.read_address = AddrW'(sb.last_written);
    else it.read_address = AddrW'(sb.written_list[$urandom_range(0, n - 1)]);
    send_item(it);
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    in_item_t it;
    for (int i = 0; i < msg.size(); i++) begin
      if ($urandom_range(0, 99) < read_pct) send_read();
      it.cmd = 1'b0;
      it.data_byte = msg[i];
      it.last_byte = (i == msg.size() - 1);
      it.read_address = AddrW'($urandom);
      send_item(it);
    end
  endtask

  task automatic send_simple(logic [7:0] kind, int len);
    logic [7:0] m[$];
    m.push_back(kind);
    repeat (len - 1) m.push_back(8'($urandom));
    send_message(m);
  endtask

  task automatic send_chunk(logic [15:0] id, logic [15:0] num, logic [15:0] total,
                            logic [15:0] len, int payload_n);
    logic [7:0] m[$];
    m.push_back(MsgChunk);
    m.push_back(id[7:0]);
    m.push_back(id[15:8]);
    m.push_back(num[7:0]);
    m.push_back(num[15:8]);
    m.push_back(total[7:0]);
    m.push_back(total[15:8]);
    m.push_back(len[7:0]);
    m.push_back(len[15:8]);
    repeat (payload_n) m.push_back(8'($urandom));
    send_message(m);
  endtask

  task automatic noise_message();
    logic [7:0] t;
    int n;
    case ($urandom_range(0, 5))
      0: send_simple(MsgSensor, 7);
      1: begin
        n = $urandom_range(1, 12);
        if (n == 7) n = 8;
        send_simple(MsgSensor, n);
      end
      2: send_simple(MsgWake, $urandom_range(1, 3));
      3: send_simple(MsgSleep, $urandom_range(1, 3));
      4: send_simple(MsgChunk, $urandom_range(1, 8));
      default: begin
        t = 8'($urandom);
        if (t >= MsgWake && t <= MsgSensor) t = {1'b1, t[6:0]};
        send_simple(t, $urandom_range(1, 4));
      end
    endcase
  endtask

  task automatic image_session();
    logic [15:0] id;
    logic [15:0] total;
    logic [15:0] num;
    logic [15:0] len;
    int pay;
    int r;
    int n;
    int c;
    r = $urandom_range(0, 99);
    if (r < 25) id = sb.cur_id;
    else if (r < 35) id = NoImageId;
    else id = 16'($urandom);
    total = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 5));
    n = (total > 5) ? 3 : int'(total);
    for (c = 0; c < n; c++) begin
      num = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(c);
      r = $urandom_range(0, 9);
      len = 16'($urandom_range(0, 24));
      pay = int'(len);
      if (r == 7) begin
        pay = $urandom_range(0, len);
      end else if (r == 8) begin
        pay = int'(len) + $urandom_range(1, 6);
      end else if (r == 9) begin
        if ($urandom_range(0, 1))
          len = 16'($urandom_range(PAYLOAD_MAX - 2, PAYLOAD_MAX + 2));
        else len = 16'($urandom_range(PAYLOAD_MAX + 1, 65535));
        pay = $urandom_range(0, 12);
      end
      send_chunk(id, num, total, len, pay);
      if ($urandom_range(0, 9) == 0) noise_message();
    end
  endtask

  // Fills the store to the last address with mostly header-only chunks, then
  // overflows it, completes it exactly and finishes the image with a dropped chunk.
  task automatic fill_session();
    logic [15:0] id;
    int tail;
    int skips;
    int total;
    int c;
    tail = 20;
    skips = (IMAGE_BYTES - tail) / PAYLOAD_MAX;
    total = skips + 5;
    id = 16'($urandom);
    if (id == sb.cur_id) id = ~id;
    for (c = 0; c < skips; c++)
      send_chunk(id, 16'(c), 16'(total), 16'(PAYLOAD_MAX),
                 (c % 8 == 3) ? $urandom_range(1, 16) : 0);
    send_chunk(id, 16'(skips), 16'(total),
               16'(IMAGE_BYTES - tail - skips * PAYLOAD_MAX), 0);
    send_chunk(id, 16'(skips + 1), 16'(total), 16'(tail), tail);
    send_chunk(id, 16'(skips + 2), 16'(total), 16'd1, 1);
    send_chunk(id, 16'(skips + 3), 16'(total), 16'd0, 0);
    send_chunk(id, 16'(skips + 4), 16'(total), 16'd3, 3);
  endtask

  initial begin
    logic [7:0] m[$];
    bit did_fill;
    bit did_long;
    int r;
    sb = new();
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    rst_ni = 1'b0;
    did_fill = 1'b0;
    did_long = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_simple(MsgWake, 1);
    send_simple(MsgSleep, 1);
    m = {MsgSensor, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
    send_message(m);
    send_simple(MsgChunk, 2);
    send_simple(8'hFF, 1);
    send_simple(8'h00, 1);
    send_chunk(NoImageId, 16'd0, 16'd1, 16'd2, 2);
    send_read();

    read_pct = 8;
    while (sb.items_in < RandomItems) begin
      if (!did_fill && sb.items_in > 300) begin
        fill_session();
        did_fill = 1'b1;
      end else if (!did_long && sb.items_in > 1000) begin
        // Runs past the point where the byte position stops counting.
        send_chunk(16'($urandom), 16'd0, 16'd1, 16'(PAYLOAD_MAX), 260);
        did_long = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) image_session();
        else if (r < 60) repeat ($urandom_range(1, 4)) send_read();
        else noise_message();
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d items including %0d store reads; checked %0d results.",
             sb.items_in, sb.reads_in, sb.checked);
    $display("Seen: %0d sensor, %0d wake, %0d sleep, %0d stored, %0d dropped, %0d done, %0d %s",
             sb.seen[StSensor], sb.seen[StWake], sb.seen[StSleep], sb.seen[StStored],
             sb.seen[StDropped], sb.seen[StDone], sb.seen[StIgnored], "ignored.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
